/* src/dcaf_pkg.sv */
`timescale 1ns / 1ps
package dcaf_pkg;

    localparam int WIDTH_BITS = 16;
    localparam int FRAC_W = 16;
    localparam int FORCE_W = 16;
    localparam int SUM_W = WIDTH_BITS + 1;
    localparam int NUM_W = WIDTH_BITS + FRAC_W + 2;
    localparam int MAG_W = NUM_W - 1;
    localparam int DEN_W = SUM_W;
    localparam int DIV_LAT = MAG_W + 1;

    localparam int RESULT_SHIFT_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int REG_IDX_W = 3;
    localparam int PADDR_W = REG_IDX_W + 2;
    localparam int PDATA_W = 32;

    localparam logic [FRAC_W:0] BIAS_SPAN = (FRAC_W + 1)'(1) << FRAC_W;
    localparam logic [FRAC_W-1:0] CAL_RESET = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic signed [FORCE_W-1:0] ZERO_SUM_FORCE = FORCE_W'(-22);

    localparam logic [REG_IDX_W-1:0] REG_GAIN_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_BIAS_X = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_Y = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_BIAS_Y = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_Z = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_BIAS_Z = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_FLIP_Y = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_THREE_AXIS = REG_IDX_W'(7);

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_READY  = 2'd1,
        STATUS_BAD_COUNTS = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [WIDTH_BITS-1:0] x_high_width;
        logic signed [WIDTH_BITS-1:0] x_low_width;
        logic signed [WIDTH_BITS-1:0] y_high_width;
        logic signed [WIDTH_BITS-1:0] y_low_width;
        logic signed [WIDTH_BITS-1:0] z_high_width;
        logic signed [WIDTH_BITS-1:0] z_low_width;
        logic                         sensor_fault;
    } in_item_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] x_force;
        logic signed [FORCE_W-1:0] y_force;
        logic signed [FORCE_W-1:0] z_force;
        logic [1:0]                result_status;
    } out_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0] gain_x;
        logic [FRAC_W-1:0] bias_x;
        logic [FRAC_W-1:0] gain_y;
        logic [FRAC_W-1:0] bias_y;
        logic [FRAC_W-1:0] gain_z;
        logic [FRAC_W-1:0] bias_z;
        logic              flip_y;
        logic              three_axis_mode;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
        logic             neg;
        logic             zero;
    } axis_job_t;

    typedef struct packed {
        axis_job_t x_job;
        axis_job_t y_job;
        axis_job_t z_job;
        status_t   status;
    } job_t;

endpackage

/* src/dcaf_front.sv */
`timescale 1ns / 1ps
module dcaf_front
    import dcaf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    output logic     push,
    output job_t     push_data,
    input  logic     full
);

    logic signed [WIDTH_BITS-1:0] hi [3];
    logic signed [WIDTH_BITS-1:0] lo [3];
    logic [FRAC_W-1:0]            bias [3];

    logic    front_en;
    status_t status_next;

    logic                    f1_valid_reg;
    status_t                 f1_status_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [NUM_W-1:0] p1_reg [3];
    logic signed [NUM_W-1:0] p2_reg [3];

    logic signed [NUM_W-1:0] num_c [3];
    logic signed [NUM_W-1:0] num_neg_c [3];
    logic signed [SUM_W-1:0] sum_neg_c [3];
    axis_job_t               axis_next [3];

    logic f2_valid_reg;
    job_t job_reg;

    assign hi[0] = in_data.x_high_width;
    assign lo[0] = in_data.x_low_width;
    assign hi[1] = in_data.y_high_width;
    assign lo[1] = in_data.y_low_width;
    assign hi[2] = in_data.z_high_width;
    assign lo[2] = in_data.z_low_width;
    assign bias[0] = cfg.bias_x;
    assign bias[1] = cfg.bias_y;
    assign bias[2] = cfg.bias_z;

    assign front_en = !f2_valid_reg || !full;
    assign in_stall = !front_en;
    assign push = f2_valid_reg && !full;
    assign push_data = job_reg;

    always_comb
    begin
        priority if (in_data.sensor_fault)
        begin
            status_next = STATUS_NOT_READY;
        end
        else if (hi[0][WIDTH_BITS-1] || (hi[0] == '0) ||
                 lo[0][WIDTH_BITS-1] || (lo[0] == '0) ||
                 hi[1][WIDTH_BITS-1] || (hi[1] == '0) ||
                 lo[1][WIDTH_BITS-1] || (lo[1] == '0))
        begin
            status_next = STATUS_BAD_COUNTS;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_c[i] = p1_reg[i] - p2_reg[i];
            num_neg_c[i] = p2_reg[i] - p1_reg[i];
            sum_neg_c[i] = -sum_reg[i];
            axis_next[i].mag = num_c[i][NUM_W-1] ? MAG_W'(num_neg_c[i]) : MAG_W'(num_c[i]);
            axis_next[i].den = sum_reg[i][SUM_W-1] ? DEN_W'(sum_neg_c[i]) : DEN_W'(sum_reg[i]);
            axis_next[i].neg = num_c[i][NUM_W-1] ^ sum_reg[i][SUM_W-1];
            axis_next[i].zero = (sum_reg[i] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f1_status_reg <= status_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= SUM_W'(hi[i]) + SUM_W'(lo[i]);
                p1_reg[i] <= NUM_W'(hi[i] * $signed({1'b0, BIAS_SPAN - {1'b0, bias[i]}}));
                p2_reg[i] <= NUM_W'($signed({1'b0, bias[i]}) * lo[i]);
            end
            job_reg.x_job <= axis_next[0];
            job_reg.y_job <= axis_next[1];
            job_reg.z_job <= axis_next[2];
            job_reg.status <= f1_status_reg;
        end
    end

endmodule

/* src/dcaf_fifo.sv */
`timescale 1ns / 1ps
module dcaf_fifo
    import dcaf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/dcaf_div.sv */
`timescale 1ns / 1ps
module dcaf_div
    import dcaf_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  axis_job_t               job,
    output logic signed [NUM_W-1:0] quo,
    output logic                    zero
);

    logic [DEN_W-1:0] rem_reg [MAG_W];
    logic [MAG_W-1:0] dq_reg [MAG_W];
    logic [DEN_W-1:0] den_reg [MAG_W];
    logic             neg_reg [MAG_W];
    logic             zero_reg [MAG_W];

    logic [DEN_W-1:0] src_rem [MAG_W];
    logic [MAG_W-1:0] src_dq [MAG_W];
    logic [DEN_W-1:0] src_den [MAG_W];
    logic             src_neg [MAG_W];
    logic             src_zero [MAG_W];

    logic [DEN_W:0] trial_c [MAG_W];
    logic [DEN_W:0] diff_c [MAG_W];
    logic           fits_c [MAG_W];

    logic signed [NUM_W-1:0] quo_reg;
    logic                    zero_out_reg;

    assign quo = quo_reg;
    assign zero = zero_out_reg;

    always_comb
    begin
        src_rem[0] = '0;
        src_dq[0] = job.mag;
        src_den[0] = job.den;
        src_neg[0] = job.neg;
        src_zero[0] = job.zero;
        for (int k = 1; k < MAG_W; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_dq[k] = dq_reg[k-1];
            src_den[k] = den_reg[k-1];
            src_neg[k] = neg_reg[k-1];
            src_zero[k] = zero_reg[k-1];
        end
        for (int k = 0; k < MAG_W; k++)
        begin
            trial_c[k] = {src_rem[k], src_dq[k][MAG_W-1]};
            diff_c[k] = trial_c[k] - {1'b0, src_den[k]};
            fits_c[k] = !diff_c[k][DEN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < MAG_W; k++)
            begin
                rem_reg[k] <= fits_c[k] ? diff_c[k][DEN_W-1:0] : trial_c[k][DEN_W-1:0];
                dq_reg[k] <= {src_dq[k][MAG_W-2:0], fits_c[k]};
                den_reg[k] <= src_den[k];
                neg_reg[k] <= src_neg[k];
                zero_reg[k] <= src_zero[k];
            end
            quo_reg <= neg_reg[MAG_W-1] ? NUM_W'(0) - NUM_W'(dq_reg[MAG_W-1])
                                        : NUM_W'(dq_reg[MAG_W-1]);
            zero_out_reg <= zero_reg[MAG_W-1];
        end
    end

endmodule

/* src/dcaf_back.sv */
`timescale 1ns / 1ps
module dcaf_back
    import dcaf_pkg::*;
#(
    parameter int RESULT_SHIFT = RESULT_SHIFT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    output logic      pop,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int MUL_W = NUM_W + FRAC_W + 1;
    localparam int PROD_W = (MUL_W > RESULT_SHIFT + FORCE_W) ? MUL_W : RESULT_SHIFT + FORCE_W;

    logic back_en;

    logic    vld_reg [DIV_LAT];
    status_t st_reg [DIV_LAT];

    axis_job_t               axis_in [3];
    logic [FRAC_W-1:0]       gain [3];
    logic signed [NUM_W-1:0] quo [3];
    logic                    zero [3];

    logic                     m_vld_reg;
    status_t                  m_st_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic                     m_zero_reg [3];

    logic signed [FORCE_W-1:0] force_c [3];

    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_next;

    assign back_en = !out_valid_reg || !out_stall;
    assign pop = back_en && head_valid;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign axis_in[0] = job.x_job;
    assign axis_in[1] = job.y_job;
    assign axis_in[2] = job.z_job;
    assign gain[0] = cfg.gain_x;
    assign gain[1] = cfg.gain_y;
    assign gain[2] = cfg.gain_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        dcaf_div u_div
        (
            .clk  (clk),
            .en   (back_en),
            .job  (axis_in[i]),
            .quo  (quo[i]),
            .zero (zero[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            force_c[i] = m_zero_reg[i] ? ZERO_SUM_FORCE : prod_reg[i][RESULT_SHIFT +: FORCE_W];
        end
        out_next.x_force = '0;
        out_next.y_force = '0;
        out_next.z_force = '0;
        out_next.result_status = m_st_reg;
        if (m_st_reg == STATUS_OK)
        begin
            out_next.x_force = force_c[0];
            out_next.y_force = cfg.flip_y ? FORCE_W'(0) - force_c[1] : force_c[1];
            out_next.z_force = cfg.three_axis_mode ? force_c[2] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            m_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            vld_reg[0] <= head_valid;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_vld_reg <= vld_reg[DIV_LAT-1];
            out_valid_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            st_reg[0] <= job.status;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                st_reg[k] <= st_reg[k-1];
            end
            m_st_reg <= st_reg[DIV_LAT-1];
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= PROD_W'($signed({1'b0, gain[i]}) * quo[i]);
                m_zero_reg[i] <= zero[i];
            end
            out_data_reg <= out_next;
        end
    end

endmodule

/* src/duty_cycle_accel_to_force.sv */
`timescale 1ns / 1ps
// Converts one snapshot of X, Y and Z duty-cycle pulse widths per transfer into calibrated
// acceleration in signed 4.12 g, one result transfer for each input transfer, in order. The
// block takes a new snapshot every clock cycle while in_stall is low; a result passes through
// the front stages, the queue write, the 33-stage restoring divider that produces one quotient
// bit per stage for each axis, the quotient sign stage, the scale multiply and the output
// register, and an output stall holds it where it is. A four-entry
// queue separates the front from the divider pipeline, so an output stall reaches the input
// only once the queue has filled. Calibration registers sit on the APB port and should be
// written only while no transfer is in flight.
module duty_cycle_accel_to_force
    import dcaf_pkg::*;
#(
    parameter int RESULT_SHIFT = RESULT_SHIFT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;

    logic push;
    job_t push_data;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_data;

    assign pready = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x <= CAL_RESET;
            cfg_reg.bias_x <= CAL_RESET;
            cfg_reg.gain_y <= CAL_RESET;
            cfg_reg.bias_y <= CAL_RESET;
            cfg_reg.gain_z <= CAL_RESET;
            cfg_reg.bias_z <= CAL_RESET;
            cfg_reg.flip_y <= 1'b0;
            cfg_reg.three_axis_mode <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_GAIN_X:     cfg_reg.gain_x <= pwdata[FRAC_W-1:0];
                REG_BIAS_X:     cfg_reg.bias_x <= pwdata[FRAC_W-1:0];
                REG_GAIN_Y:     cfg_reg.gain_y <= pwdata[FRAC_W-1:0];
                REG_BIAS_Y:     cfg_reg.bias_y <= pwdata[FRAC_W-1:0];
                REG_GAIN_Z:     cfg_reg.gain_z <= pwdata[FRAC_W-1:0];
                REG_BIAS_Z:     cfg_reg.bias_z <= pwdata[FRAC_W-1:0];
                REG_FLIP_Y:     cfg_reg.flip_y <= pwdata[0];
                REG_THREE_AXIS: cfg_reg.three_axis_mode <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_X:     prdata = PDATA_W'(cfg_reg.gain_x);
            REG_BIAS_X:     prdata = PDATA_W'(cfg_reg.bias_x);
            REG_GAIN_Y:     prdata = PDATA_W'(cfg_reg.gain_y);
            REG_BIAS_Y:     prdata = PDATA_W'(cfg_reg.bias_y);
            REG_GAIN_Z:     prdata = PDATA_W'(cfg_reg.gain_z);
            REG_BIAS_Z:     prdata = PDATA_W'(cfg_reg.bias_z);
            REG_FLIP_Y:     prdata = PDATA_W'(cfg_reg.flip_y);
            REG_THREE_AXIS: prdata = PDATA_W'(cfg_reg.three_axis_mode);
        endcase
    end

    dcaf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    dcaf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    dcaf_back #(
        .RESULT_SHIFT (RESULT_SHIFT)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .pop        (pop),
        .job        (head_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
